// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
// Both macros clock on clk_i; the first one also masks checks while in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while rst_ni is high.
`define ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, during reset too.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/crc16fr_pkg.sv -----
`timescale 1ns / 1ps

package crc16fr_pkg;

  // Frame length in bytes, including the two trailing CRC bytes.
  localparam int unsigned FrameLen = 25;
  localparam int unsigned CountW   = 5;
  localparam int unsigned OffsetW  = 5;
  localparam int unsigned PaddrW   = 3;

  localparam logic [CountW-1:0] DataLen  = CountW'(FrameLen - 2);
  localparam logic [CountW-1:0] LastPos  = CountW'(FrameLen - 1);

  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  localparam logic [OffsetW-1:0] OffsetReset = OffsetW'(13);

  // Register byte addresses.
  localparam logic [PaddrW-1:0] AddrValueOffset = '0;

  typedef enum logic {
    CmdData  = 1'b0,
    CmdAbort = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StCrcErr  = 2'd1,
    StDiscard = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] value;
    status_e            status;
  } out_word_t;

endpackage

// ----- rtl/crc16_frame_value_receiver.sv -----
`timescale 1ns / 1ps
// CRC-16/MODBUS frame receiver with value capture.
// Input channel (in_valid_i / in_stall_o / in_word_i): one word per frame byte,
// or an abort word. A frame is FrameLen bytes; the CRC (poly 0xA001, init
// 0xFFFF) covers all but the last two bytes, which carry the CRC high byte
// first. A little-endian signed 16-bit value is picked from the byte offset
// held in the value_offset register (APB address 0, reset 13).
// Output channel (out_valid_o / out_stall_i / out_word_o): one word per frame
// end (status ok or CRC error) and one per abort (status discarded).
// The result of the last byte or the abort is registered in out_word_q, or in
// the skid register while the output stalls. One input word is accepted
// every cycle while in_stall_o is low; the whole byte update is one registered
// pass of an eight-step bit-wise CRC shift on the running CRC register.
// When the output stalls, one further result is parked in a skid register;
// in_stall_o rises only while that skid register is full.
// Reset clears the frame state (CRC to 0xFFFF, byte count to zero), empties
// both output registers and loads value_offset with 13.
// value_offset may only be written while no frame is in progress.
module crc16_frame_value_receiver
  import crc16fr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_word_t          in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_word_t         out_word_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

`include "assert_macros.svh"

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
    end
    return crc;
  endfunction

  // Configuration register.
  logic [OffsetW-1:0] value_offset_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == AddrValueOffset);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_offset_q <= OffsetReset;
    end else if (cfg_wr) begin
      value_offset_q <= pwdata[OffsetW-1:0];
    end
  end

  assign prdata = (paddr == AddrValueOffset) ? {{(32-OffsetW){1'b0}}, value_offset_q} : '0;

  // Frame state.
  logic [15:0]       running_crc_q, running_crc_d;
  logic [CountW-1:0] byte_count_q, byte_count_d;
  logic [15:0]       captured_q, captured_d;
  logic [7:0]        crc_high_q, crc_high_d;

  logic      in_acc;
  logic      res_valid;
  out_word_t res_word;

  assign in_acc = in_valid_i && !in_stall_o;

  // Position compares are one bit wider so that offset + 1 never wraps.
  logic [CountW:0] pos_ext, off_ext, off_next;
  assign pos_ext  = {1'b0, byte_count_q};
  assign off_ext  = {1'b0, value_offset_q};
  assign off_next = off_ext + 1'b1;

  always_comb begin
    running_crc_d = running_crc_q;
    byte_count_d  = byte_count_q;
    captured_d    = captured_q;
    crc_high_d    = crc_high_q;
    res_valid     = 1'b0;
    res_word      = '{value: '0, status: StOk};

    if (in_acc) begin
      if (in_word_i.cmd == CmdAbort) begin
        running_crc_d = CrcInit;
        byte_count_d  = '0;
        res_valid     = 1'b1;
        res_word      = '{value: '0, status: StDiscard};
      end else begin
        // The value is cleared at the start of each frame, then its bytes
        // are picked up wherever they fall, CRC bytes included.
        if (byte_count_q == '0) begin
          captured_d = '0;
        end
        if (pos_ext == off_ext) begin
          captured_d[7:0] = in_word_i.rx_byte;
        end
        if (pos_ext == off_next) begin
          captured_d[15:8] = in_word_i.rx_byte;
        end

        byte_count_d = byte_count_q + 1'b1;
        if (byte_count_q < DataLen) begin
          running_crc_d = crc_byte(running_crc_q, in_word_i.rx_byte);
        end else if (byte_count_q == DataLen) begin
          crc_high_d = in_word_i.rx_byte;
        end else begin
          running_crc_d = CrcInit;
          byte_count_d  = '0;
          res_valid     = 1'b1;
          if ({crc_high_q, in_word_i.rx_byte} == running_crc_q) begin
            res_word = '{value: captured_d, status: StOk};
          end else begin
            res_word = '{value: '0, status: StCrcErr};
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_crc_q <= CrcInit;
      byte_count_q  <= '0;
      captured_q    <= '0;
      crc_high_q    <= '0;
    end else begin
      running_crc_q <= running_crc_d;
      byte_count_q  <= byte_count_d;
      captured_q    <= captured_d;
      crc_high_q    <= crc_high_d;
    end
  end

  // Output register plus skid register.
  logic      out_valid_q, out_valid_d;
  logic      skid_valid_q, skid_valid_d;
  out_word_t out_word_q, out_word_d;
  out_word_t skid_word_q, skid_word_d;
  logic      out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_word_d   = out_word_q;
    skid_valid_d = skid_valid_q;
    skid_word_d  = skid_word_q;
    if (out_free) begin
      // No input is taken while the skid register is full.
      out_valid_d  = skid_valid_q || res_valid;
      out_word_d   = skid_valid_q ? skid_word_q : res_word;
      skid_valid_d = 1'b0;
    end else if (res_valid) begin
      skid_valid_d = 1'b1;
      skid_word_d  = res_word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q  <= out_word_d;
    skid_word_q <= skid_word_d;
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  `ASSERT_ALWAYS(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid full while output empty")
  `ASSERT_RUN(a_count_range, byte_count_q <= LastPos, "byte count past frame end")
  `ASSERT_RUN(a_result_shows, (in_acc && res_valid) |=> out_valid_q, "result was dropped")
  `ASSERT_RUN(a_abort_restart, (in_acc && in_word_i.cmd == CmdAbort) |=> (byte_count_q == '0 && running_crc_q == CrcInit), "abort did not restart the frame")

endmodule

// ----- tb/crc16_frame_value_receiver_checker.sv -----
`timescale 1ns / 1ps

package crc16fr_tb_pkg;

  import crc16fr_pkg::*;

  // One byte through the reflected CRC-16/MODBUS register, LSB first.
  function automatic logic [15:0] crc16_modbus_byte(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    int          k;
    c = crc ^ {8'h00, data};
    for (k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

module crc16_frame_value_receiver_checker
  import crc16fr_pkg::*;
  import crc16fr_tb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_word_t          in_word_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_word_t         out_word_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output int unsigned       error_count_o = 0,
  output int unsigned       pending_o = 0
);

  out_word_t          frame_result_q[$];
  logic [15:0]        frame_crc;
  logic [CountW-1:0]  frame_pos;
  logic [15:0]        frame_value;
  logic [7:0]         crc_high;
  logic [OffsetW-1:0] value_offset;

  task automatic predict_word(input in_word_t w);
    out_word_t res;
    if (w.cmd == CmdAbort) begin
      frame_crc  = CrcInit;
      frame_pos  = '0;
      res.value  = '0;
      res.status = StDiscard;
      frame_result_q.push_back(res);
    end else begin
      if (frame_pos == '0) frame_value = '0;
      if (int'(frame_pos) == int'(value_offset)) frame_value[7:0] = w.rx_byte;
      if (int'(frame_pos) == int'(value_offset) + 1) frame_value[15:8] = w.rx_byte;
      if (frame_pos < DataLen) begin
        frame_crc = crc16_modbus_byte(frame_crc, w.rx_byte);
        frame_pos = frame_pos + 1'b1;
      end else if (frame_pos == DataLen) begin
        crc_high  = w.rx_byte;
        frame_pos = frame_pos + 1'b1;
      end else begin
        if ({crc_high, w.rx_byte} == frame_crc) begin
          res.value  = frame_value;
          res.status = StOk;
        end else begin
          res.value  = '0;
          res.status = StCrcErr;
        end
        frame_crc = CrcInit;
        frame_pos = '0;
        frame_result_q.push_back(res);
      end
    end
  endtask

  task automatic check_word(input out_word_t got);
    out_word_t want;
    if (frame_result_q.size() == 0) begin
      $display("%0t: result word with none expected, got value %0d status %0d",
               $time, got.value, got.status);
      error_count_o++;
    end else begin
      want = frame_result_q.pop_front();
      if (got.value !== want.value) begin
        $display("%0t: value mismatch, expected %0d, got %0d", $time, want.value, got.value);
        error_count_o++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d, got %0d",
                 $time, want.status, got.status);
        error_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_crc    = CrcInit;
      frame_pos    = '0;
      frame_value  = '0;
      crc_high     = '0;
      value_offset = OffsetReset;
      frame_result_q.delete();
      pending_o    = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr == AddrValueOffset) begin
        value_offset = pwdata[OffsetW-1:0];
      end
      if (in_valid_i && !in_stall_i) predict_word(in_word_i);
      if (out_valid_i && !out_stall_i) check_word(out_word_i);
      pending_o = frame_result_q.size();
    end
  end

endmodule

// ----- tb/crc16_frame_value_receiver_tb.sv -----
`timescale 1ns / 1ps

module crc16_frame_value_receiver_tb;

  import crc16fr_pkg::*;
  import crc16fr_tb_pkg::*;

  localparam int          ClkPeriod   = 10;
  localparam int          ResetCycles = 4;
  // Number of random input words, split into phases with one offset setting each.
  localparam int unsigned RandomItems = 900;
  localparam int unsigned PhaseItems  = 150;
  // Extra wait once every expected result is back, covering the skid register draining.
  localparam int          DrainCycles = 8;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned IdlePct     = 15;
  // Phase in which neither side idles.
  localparam int unsigned QuietPhase  = 2;
  localparam int unsigned MaxOffset   = 21;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_word_t          in_word   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_word_t         out_word;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [PaddrW-1:0] paddr     = '0;
  logic [31:0]       pwdata    = '0;
  logic [31:0]       prdata;
  logic              pready;

  int unsigned        error_count;
  int unsigned        pending;
  int unsigned        cycles      = 0;
  int unsigned        items_sent  = 0;
  bit                 quiet       = 1'b0;
  // Offset the block holds right now; frames place their value bytes there.
  logic [OffsetW-1:0] cur_offset  = OffsetReset;

  always #(ClkPeriod / 2) clk = ~clk;

  crc16_frame_value_receiver i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // The checker watches both channels and the register port on its own and
  // keeps the expected results; this module only drives and judges.
  crc16_frame_value_receiver_checker i_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .in_word_i     (in_word),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .out_word_i    (out_word),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .error_count_o (error_count),
    .pending_o     (pending)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // The receiving side stalls at random, except during the quiet phase.
  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < IdlePct);
  end

  // Offers one word and holds it until the block takes it. Idle cycles are
  // decided before valid rises, so valid never looks at the stall. Valid is
  // only lowered inside the idle loop, which keeps back-to-back words from
  // seeing a low and a high assignment in the same time step.
  task automatic send_word(input cmd_e cmd, input logic [7:0] data);
    while (!quiet && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_word.cmd     <= cmd;
    in_word.rx_byte <= data;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  // Sends one whole frame with the value at the current offset and a CRC
  // that matches. With corrupt set, one bit anywhere in the frame is flipped,
  // which CRC-16 always catches. The striped frame alternates 0x00 and 0xFF
  // bytes and carries the most negative value.
  task automatic send_frame(input bit corrupt, input bit striped);
    logic [7:0]  frame_bytes [FrameLen];
    logic [15:0] crc;
    logic [15:0] val;
    int unsigned flip;
    for (int i = 0; i < FrameLen; i++) begin
      frame_bytes[i] = striped ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom_range(255));
    end
    if (striped) begin
      val = 16'h8000;
    end else begin
      case ($urandom_range(5))
        0:       val = 16'h7FFF;
        1:       val = 16'h8000;
        2:       val = 16'h0000;
        3:       val = 16'hFFFF;
        default: val = 16'($urandom_range(16'hFFFF));
      endcase
    end
    frame_bytes[cur_offset]     = val[7:0];
    frame_bytes[cur_offset + 1] = val[15:8];
    crc = CrcInit;
    for (int i = 0; i < DataLen; i++) begin
      crc = crc16_modbus_byte(crc, frame_bytes[i]);
    end
    // The CRC travels high byte first.
    frame_bytes[DataLen] = crc[15:8];
    frame_bytes[LastPos] = crc[7:0];
    if (corrupt) begin
      flip = $urandom_range(FrameLen * 8 - 1);
      frame_bytes[flip / 8][flip % 8] = ~frame_bytes[flip / 8][flip % 8];
    end
    for (int i = 0; i < FrameLen; i++) begin
      send_word(CmdData, frame_bytes[i]);
    end
  endtask

  // Stops sending, waits until every expected word has come back, then lets
  // the block drain so that nothing is left in flight.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Register write: a setup phase, then an access phase held until pready.
  task automatic apb_write(input logic [PaddrW-1:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_end;
    int unsigned kind;
    int unsigned n;

    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, at the reset offset. An abort with no frame in flight
    // still reports a discarded frame, and its data byte is ignored.
    send_word(CmdAbort, 8'hFF);
    // A clean frame of alternating extreme bytes carrying -32768.
    send_frame(1'b0, 1'b1);

    // Random part. Each phase starts with an abort so that no frame is in
    // progress, waits for the block to go idle (the sender pauses until every
    // expected word is back), and then moves the value offset. The phases
    // cover both ends of the offset range and the reset value.
    items_sent = 0;
    phase      = 0;
    while (items_sent < RandomItems) begin
      send_word(CmdAbort, 8'($urandom_range(255)));
      settle();
      case (phase)
        0:       cur_offset = '0;
        1:       cur_offset = OffsetW'(MaxOffset);
        2:       cur_offset = OffsetReset;
        default: cur_offset = OffsetW'($urandom_range(MaxOffset));
      endcase
      apb_write(AddrValueOffset, 32'(cur_offset));
      quiet     = (phase == QuietPhase);
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end && items_sent < RandomItems) begin
        kind = $urandom_range(99);
        if (kind < 65) begin
          send_frame(1'b0, 1'b0);
        end else if (kind < 78) begin
          send_frame(1'b1, 1'b0);
        end else if (kind < 90) begin
          // A partial frame cut short by an abort, up to one byte short of
          // the full length.
          n = $urandom_range(LastPos);
          repeat (n) send_word(CmdData, 8'($urandom_range(255)));
          send_word(CmdAbort, 8'($urandom_range(255)));
        end else begin
          // Noise: a short burst of random words with occasional aborts,
          // which leaves the frame position anywhere.
          repeat ($urandom_range(8, 1)) begin
            send_word(cmd_e'($urandom_range(3) == 0), 8'($urandom_range(255)));
          end
        end
      end
      phase++;
    end

    // Close the last frame, drain everything, and give the verdict.
    quiet = 1'b0;
    send_word(CmdAbort, 8'h00);
    settle();
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/crc16fr_pkg.sv
rtl/crc16_frame_value_receiver.sv
tb/crc16_frame_value_receiver_checker.sv
tb/crc16_frame_value_receiver_tb.sv
